[src/fpac_pkg.sv]
// Shared constants for the additive-checksum frame parser.
// Depends on nothing; imported by frame_parser_additive_checksum.
package fpac_pkg;

  localparam int HEADER_BYTES     = 10;
  localparam int BODY_MAX_DEFAULT = 16384;
  localparam int CFG_W            = 15;
  localparam logic [CFG_W-1:0] MAX_BODY_RESET = 15'd10230;

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HDR_OK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HDR_ERR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LEN_ERR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BODY_OK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BODY_ERR = 3'd5;

endpackage

[src/frame_parser_additive_checksum.sv]
// Frame parser top level: header collection, payload pass-through and
// additive checksum and length checks. Depends on fpac_pkg.
//
//  channel | direction | signals                                  | beat
//  --------+-----------+------------------------------------------+-----------------------
//  rx      | in        | in_valid, in_stall, rx_byte              | one stream byte
//  result  | out       | out_valid, out_stall, result_kind, ...   | one status or payload
//  config  | in        | cfg_we, cfg_wdata                        | max_body_length write
//
// One byte is accepted every cycle while in_stall is low; its result passes through
// the input register and the result register. Per payload byte the update is a
// 16-bit sum add, a count increment and a length compare. Header bytes 0 to 8 and the
// body checksum high byte produce no result. Reset returns to header collection
// with max_body_length at its reset value. A stall on the result side holds the
// result register and backs up into the input register, then into in_stall.
module frame_parser_additive_checksum #(
  parameter int BODY_MAX = fpac_pkg::BODY_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fpac_pkg::KIND_W-1:0]   result_kind,
  output logic [7:0]                    payload_byte,
  output logic [15:0]                   packet_type,
  output logic [31:0]                   body_length,
  output logic                          is_last,
  input  logic                          cfg_we,
  input  logic [fpac_pkg::CFG_W-1:0]    cfg_wdata
);
  import fpac_pkg::*;

  localparam int CW = $clog2(BODY_MAX + 1);
  localparam logic [31:0] BODY_MAX_W = 32'(BODY_MAX);
  localparam logic [3:0] HDR_SUM_HI = 4'(HEADER_BYTES - 2);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_SUM_HI  = 2'd2;
  localparam logic [1:0] PH_SUM_LO  = 2'd3;

  logic [CFG_W-1:0] max_body_length;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;

  logic [1:0]    phase, phase_next;
  logic [3:0]    hdr_count, hdr_count_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [CW-1:0] last_count, last_count_next;
  logic [15:0]   running_sum, running_sum_next;
  logic [15:0]   type_value, type_value_next;
  logic [31:0]   length_value, length_value_next;
  logic [7:0]    checksum_high_byte, checksum_high_byte_next;

  logic              has_result;
  logic [KIND_W-1:0] kind;
  logic              last;
  logic [31:0]       limit;
  logic [15:0]       rx_sum;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= MAX_BODY_RESET;
    end else if (cfg_we) begin
      max_body_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  assign limit  = ({17'd0, max_body_length} > BODY_MAX_W) ? BODY_MAX_W
                                                          : {17'd0, max_body_length};
  assign rx_sum = {checksum_high_byte, s1_byte};

  always_comb begin
    phase_next              = phase;
    hdr_count_next          = hdr_count;
    byte_count_next         = byte_count;
    last_count_next         = last_count;
    running_sum_next        = running_sum;
    type_value_next         = type_value;
    length_value_next       = length_value;
    checksum_high_byte_next = checksum_high_byte;
    has_result              = 1'b0;
    kind                    = KIND_PAYLOAD;
    last                    = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (hdr_count < HDR_SUM_HI) begin
          running_sum_next = running_sum + {8'd0, s1_byte};
          if (hdr_count < 4'd4) begin
            type_value_next = {type_value[7:0], s1_byte};
          end else begin
            length_value_next = {length_value[23:0], s1_byte};
          end
          hdr_count_next = hdr_count + 4'd1;
        end else if (hdr_count == HDR_SUM_HI) begin
          checksum_high_byte_next = s1_byte;
          hdr_count_next = hdr_count + 4'd1;
        end else begin
          has_result              = 1'b1;
          hdr_count_next          = 4'd0;
          running_sum_next        = 16'd0;
          checksum_high_byte_next = 8'd0;
          byte_count_next         = '0;
          if (rx_sum != running_sum) begin
            kind = KIND_HDR_ERR;
          end else if (length_value < 32'd2 || length_value > limit) begin
            kind = KIND_LEN_ERR;
          end else begin
            kind = KIND_HDR_OK;
            // Length is known to fit CW bits here.
            last_count_next = length_value[CW-1:0] - CW'(2);
            phase_next = (length_value == 32'd2) ? PH_SUM_HI : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_result       = 1'b1;
        kind             = KIND_PAYLOAD;
        running_sum_next = running_sum + {8'd0, s1_byte};
        byte_count_next  = byte_count + CW'(1);
        last             = (byte_count_next == last_count);
        if (last) begin
          phase_next = PH_SUM_HI;
        end
      end
      PH_SUM_HI: begin
        checksum_high_byte_next = s1_byte;
        phase_next = PH_SUM_LO;
      end
      default: begin
        has_result = 1'b1;
        kind = (rx_sum == running_sum) ? KIND_BODY_OK : KIND_BODY_ERR;
        phase_next              = PH_HEADER;
        hdr_count_next          = 4'd0;
        byte_count_next         = '0;
        running_sum_next        = 16'd0;
        checksum_high_byte_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      hdr_count          <= 4'd0;
      byte_count         <= '0;
      last_count         <= '0;
      running_sum        <= 16'd0;
      type_value         <= 16'd0;
      length_value       <= 32'd0;
      checksum_high_byte <= 8'd0;
    end else if (s1_valid && adv) begin
      phase              <= phase_next;
      hdr_count          <= hdr_count_next;
      byte_count         <= byte_count_next;
      last_count         <= last_count_next;
      running_sum        <= running_sum_next;
      type_value         <= type_value_next;
      length_value       <= length_value_next;
      checksum_high_byte <= checksum_high_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && has_result;
    end
  end

  // Type and length come from the updated header values, as they stand after this byte.
  always_ff @(posedge clk) begin
    if (adv && s1_valid && has_result) begin
      result_kind  <= kind;
      payload_byte <= (kind == KIND_PAYLOAD) ? s1_byte : 8'd0;
      packet_type  <= type_value_next;
      body_length  <= length_value_next;
      is_last      <= last;
    end
  end

endmodule
